// File: hdl/rbi_pkg.sv
// Shared constants, codes and types of the rectilinear bilinear interpolator.
package rbi_pkg;

   localparam int DEF_MAX_X_POINTS = 256;
   localparam int DEF_MAX_Y_POINTS = 256;
   localparam int DEF_VALUE_WIDTH  = 32;

   localparam int COORD_W    = 32;   // Q16.16 coordinates and samples
   localparam int DIFF_W     = 33;   // exact coordinate differences
   localparam int MUL_W      = 34;   // shared multiplier operand width
   localparam int PROD_W     = 2 * MUL_W;
   localparam int AREA_W     = 2 * DIFF_W;
   localparam int ACC_W      = 100;  // sum of four sample*dx*dy terms
   localparam int DEN_W      = 64;   // magnitude of the cell area
   localparam int COUNT_W    = 9;
   localparam int REQ_DATA_W = 112;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_LOAD_X    = 2'd0,
      OP_LOAD_Y    = 2'd1,
      OP_LOAD_GRID = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   localparam logic REG_X_COUNT = 1'b0;
   localparam logic REG_Y_COUNT = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: hdl/rbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rbi_mul.sv
// Shared signed multiplier with a registered product.
module rbi_mul (
   input  logic                               clock,
   input  logic signed [rbi_pkg::MUL_W-1:0]   a,
   input  logic signed [rbi_pkg::MUL_W-1:0]   b,
   output logic signed [rbi_pkg::PROD_W-1:0]  p
);
   import rbi_pkg::*;

   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] p_in;

   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// File: hdl/rbi_div.sv
// Restoring divider, one quotient bit per cycle.
module rbi_div #(
   parameter int NUM_W = 100,
   parameter int DEN_W = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic [NUM_W-1:0]           quot,
   output rbi_pkg::div_stat_type      stat
);
   import rbi_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] nq_ff, nq_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, nq_ff[NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      nq_in   = nq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         nq_in   = num;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         nq_in  = {nq_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      nq_ff  <= nq_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot      = nq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: hdl/rectilinear_bilinear_interpolator.sv
// Top level of the rectilinear bilinear interpolator: sequencer, tables and grid.
//
// Requests enter on req_ (tuser = op). Load requests write one x coordinate,
// y coordinate or grid sample and give no response. A query request runs an
// upper-bound binary search on both axes at once (each step a pass through
// SRCH and SCMP, one table read each), reads the four bounding coordinates,
// then drives one shared 34x34 multiplier through the cell area and the four
// sample*dx*dy terms, and a restoring divider that forms the quotient bit by
// bit. A query in range spends most of its time in the divider; a point outside
// the grid skips the reads, the multiplier and the divider. One request is
// worked at a time; req_tready is high only between requests. The response
// sits in an output register, so the next request is taken while it waits; a
// stalled rsp_ side holds a finished query until it is taken. Reset clears the
// sequencer and the response valid, and sets both counts to 256. Tables and
// grid are not cleared: an entry must be written before use. The user must
// write x_count (address 0) and y_count (address 4) over the csr_ port only
// while no request is in work; the block itself does not enforce this.
module rectilinear_bilinear_interpolator #(
   parameter int MAX_X_POINTS = rbi_pkg::DEF_MAX_X_POINTS,
   parameter int MAX_Y_POINTS = rbi_pkg::DEF_MAX_Y_POINTS,
   parameter int VALUE_WIDTH  = rbi_pkg::DEF_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // index_i[7:0], index_j[15:8], load_value[47:16], query_x[79:48], query_y[111:80]
   input  logic [rbi_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result[31:0]
   output logic [rbi_pkg::COORD_W-1:0]       rsp_tdata,
   // out_of_range[0]
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rbi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rbi_pkg::*;

   localparam int AWX = $clog2(MAX_X_POINTS);
   localparam int AWY = $clog2(MAX_Y_POINTS);
   localparam int CWX = $clog2(MAX_X_POINTS + 1);
   localparam int CWY = $clog2(MAX_Y_POINTS + 1);
   localparam int GAW = AWX + AWY;
   localparam logic [ACC_W-1:0] MAXPOS =
      {{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_SRCH = 11'b00000000010,
      ST_SCMP = 11'b00000000100,
      ST_CHK  = 11'b00000001000,
      ST_RD   = 11'b00000010000,
      ST_DIFF = 11'b00000100000,
      ST_AREA = 11'b00001000000,
      ST_MAC  = 11'b00010000000,
      ST_DCHK = 11'b00100000000,
      ST_DIV  = 11'b01000000000,
      ST_OUT  = 11'b10000000000
   } st_type;

   // request fields
   op_type                     op;
   logic [7:0]                 ii, jj;
   logic [COORD_W-1:0]         lv;
   logic signed [COORD_W-1:0]  qx, qy;

   assign op = op_type'(req_tuser);
   assign ii = req_tdata[7:0];
   assign jj = req_tdata[15:8];
   assign lv = req_tdata[47:16];
   assign qx = signed'(req_tdata[79:48]);
   assign qy = signed'(req_tdata[111:80]);

   st_type                     st_ff, st_in;
   logic [COUNT_W-1:0]         x_count_ff, y_count_ff;
   logic signed [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [CWX-1:0]             nx_ff, nx_in, fx_ff, fx_in, lx_ff, lx_in;
   logic [CWY-1:0]             ny_ff, ny_in, fy_ff, fy_in, ly_ff, ly_in;
   logic [1:0]                 cnt_ff, cnt_in, term_ff, term_in, ph_ff, ph_in;
   logic signed [COORD_W-1:0]  x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic signed [DIFF_W-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic signed [DIFF_W-1:0]   dx0_ff, dx0_in, dx1_ff, dx1_in, dy0_ff, dy0_in, dy1_ff, dy1_in;
   logic signed [AREA_W-1:0]   area_ff, area_in;
   logic signed [DIFF_W-1:0]   phi_ff, phi_in;
   logic signed [COORD_W-1:0]  s_ff, s_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic [COORD_W-1:0]         res_ff, res_in;
   logic                       oor_ff, oor_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                       rsp_oor_ff, rsp_oor_in;

   logic                       req_acc, cfg_we;
   logic [CWX-1:0]             hx, midx, nx_clamp;
   logic [CWY-1:0]             hy, midy, ny_clamp;
   logic [AWX-1:0]             i0, i1, gi, x_rd_addr;
   logic [AWY-1:0]             j0, j1, gj, y_rd_addr;
   logic [COORD_W-1:0]         x_rd, y_rd, g_rd;
   logic                       x_we, y_we, g_we;
   logic                       lt_x, lt_y;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [DIFF_W-1:0]   da, db;
   logic                       div_start;
   logic [ACC_W-1:0]           num_mag, quot, sat_m, sat_neg;
   logic [AREA_W-1:0]          area_mag;
   div_stat_type               div_stat;

   assign req_tready = (st_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_Y_COUNT) ?
                       CSR_DATA_W'(y_count_ff) : CSR_DATA_W'(x_count_ff);

   // clamp counts into 2..depth
   always_comb begin
      if (x_count_ff < COUNT_W'(2)) begin
         nx_clamp = CWX'(2);
      end else if (int'(x_count_ff) > MAX_X_POINTS) begin
         nx_clamp = CWX'(MAX_X_POINTS);
      end else begin
         nx_clamp = CWX'(x_count_ff);
      end
      if (y_count_ff < COUNT_W'(2)) begin
         ny_clamp = CWY'(2);
      end else if (int'(y_count_ff) > MAX_Y_POINTS) begin
         ny_clamp = CWY'(MAX_Y_POINTS);
      end else begin
         ny_clamp = CWY'(y_count_ff);
      end
   end

   assign hx   = lx_ff >> 1;
   assign hy   = ly_ff >> 1;
   assign midx = fx_ff + hx;
   assign midy = fy_ff + hy;
   assign i1   = fx_ff[AWX-1:0];
   assign j1   = fy_ff[AWY-1:0];
   assign i0   = i1 - AWX'(1);
   assign j0   = j1 - AWY'(1);
   assign gi   = term_ff[0] ? i1 : i0;
   assign gj   = term_ff[1] ? j1 : j0;
   assign da   = term_ff[0] ? dx0_ff : dx1_ff;
   assign db   = term_ff[1] ? dy0_ff : dy1_ff;

   assign x_rd_addr = (st_ff == ST_RD) ? ((cnt_ff == 2'd0) ? i0 : i1) : midx[AWX-1:0];
   assign y_rd_addr = (st_ff == ST_RD) ? ((cnt_ff == 2'd0) ? j0 : j1) : midy[AWY-1:0];

   assign lt_x = px_ff < signed'(x_rd);
   assign lt_y = py_ff < signed'(y_rd);

   assign x_we = req_acc && (op == OP_LOAD_X) && (int'(ii) < MAX_X_POINTS);
   assign y_we = req_acc && (op == OP_LOAD_Y) && (int'(jj) < MAX_Y_POINTS);
   assign g_we = req_acc && (op == OP_LOAD_GRID) &&
                 (int'(ii) < MAX_X_POINTS) && (int'(jj) < MAX_Y_POINTS);

   rbi_ram #(.WIDTH(COORD_W), .DEPTH(MAX_X_POINTS)) u_x_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (AWX'(ii)),
      .wr_data (lv),
      .rd_addr (x_rd_addr),
      .rd_data (x_rd)
   );

   rbi_ram #(.WIDTH(COORD_W), .DEPTH(MAX_Y_POINTS)) u_y_ram (
      .clock   (clock),
      .wr_en   (y_we),
      .wr_addr (AWY'(jj)),
      .wr_data (lv),
      .rd_addr (y_rd_addr),
      .rd_data (y_rd)
   );

   rbi_ram #(.WIDTH(COORD_W), .DEPTH(1 << GAW)) u_grid_ram (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr ({AWX'(ii), AWY'(jj)}),
      .wr_data (lv),
      .rd_addr ({gi, gj}),
      .rd_data (g_rd)
   );

   // operand select for the shared multiplier
   always_comb begin
      mul_a = MUL_W'(ax_ff);
      mul_b = MUL_W'(ay_ff);
      if (st_ff == ST_MAC) begin
         case (ph_ff)
            2'd0: begin
               mul_a = MUL_W'(da);
               mul_b = MUL_W'(db);
            end
            2'd1: begin
               mul_a = MUL_W'(signed'(g_rd));
               mul_b = signed'({1'b0, mul_p[DIFF_W-1:0]});
            end
            2'd2: begin
               mul_a = MUL_W'(s_ff);
               mul_b = MUL_W'(phi_ff);
            end
            default: begin
               mul_a = MUL_W'(ax_ff);
               mul_b = MUL_W'(ay_ff);
            end
         endcase
      end
   end

   rbi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   assign num_mag  = acc_ff[ACC_W-1] ? ACC_W'(0) - acc_ff : acc_ff;
   assign area_mag = area_ff[AREA_W-1] ? AREA_W'(0) - area_ff : area_ff;
   assign div_start = (st_ff == ST_DCHK) && (area_ff != '0);

   rbi_div #(.NUM_W(ACC_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_mag),
      .den   (area_mag[DEN_W-1:0]),
      .quot  (quot),
      .stat  (div_stat)
   );

   // saturate the quotient magnitude, then apply the sign
   always_comb begin
      if (!neg_ff) begin
         sat_m = (quot > MAXPOS) ? MAXPOS : quot;
      end else begin
         sat_m = (quot > MAXPOS + ACC_W'(1)) ? MAXPOS + ACC_W'(1) : quot;
      end
      sat_neg = ACC_W'(0) - sat_m;
   end

   always_comb begin
      st_in        = st_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      fx_in        = fx_ff;
      lx_in        = lx_ff;
      fy_in        = fy_ff;
      ly_in        = ly_ff;
      cnt_in       = cnt_ff;
      term_in      = term_ff;
      ph_in        = ph_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      dx0_in       = dx0_ff;
      dx1_in       = dx1_ff;
      dy0_in       = dy0_ff;
      dy1_in       = dy1_ff;
      area_in      = area_ff;
      phi_in       = phi_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_oor_in   = rsp_oor_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (st_ff)
         ST_IDLE: begin
            if (req_acc && (op == OP_QUERY)) begin
               px_in = qx;
               py_in = qy;
               nx_in = nx_clamp;
               ny_in = ny_clamp;
               fx_in = '0;
               fy_in = '0;
               lx_in = nx_clamp;
               ly_in = ny_clamp;
               st_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            st_in = (lx_ff == '0 && ly_ff == '0) ? ST_CHK : ST_SCMP;
         end
         ST_SCMP: begin
            if (lx_ff != '0) begin
               if (!lt_x) begin
                  fx_in = midx + CWX'(1);
                  lx_in = lx_ff - hx - CWX'(1);
               end else begin
                  lx_in = hx;
               end
            end
            if (ly_ff != '0) begin
               if (!lt_y) begin
                  fy_in = midy + CWY'(1);
                  ly_in = ly_ff - hy - CWY'(1);
               end else begin
                  ly_in = hy;
               end
            end
            st_in = ST_SRCH;
         end
         ST_CHK: begin
            if (fx_ff == nx_ff || fy_ff == ny_ff || fx_ff == '0 || fy_ff == '0) begin
               res_in = '0;
               oor_in = 1'b1;
               st_in  = ST_OUT;
            end else begin
               cnt_in = 2'd0;
               st_in  = ST_RD;
            end
         end
         ST_RD: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               x0_in = signed'(x_rd);
               y0_in = signed'(y_rd);
            end else if (cnt_ff == 2'd2) begin
               x1_in = signed'(x_rd);
               y1_in = signed'(y_rd);
               st_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            ax_in  = DIFF_W'(x1_ff) - DIFF_W'(x0_ff);
            ay_in  = DIFF_W'(y1_ff) - DIFF_W'(y0_ff);
            dx0_in = DIFF_W'(px_ff) - DIFF_W'(x0_ff);
            dx1_in = DIFF_W'(x1_ff) - DIFF_W'(px_ff);
            dy0_in = DIFF_W'(py_ff) - DIFF_W'(y0_ff);
            dy1_in = DIFF_W'(y1_ff) - DIFF_W'(py_ff);
            st_in  = ST_AREA;
         end
         ST_AREA: begin
            acc_in  = '0;
            term_in = 2'd0;
            ph_in   = 2'd0;
            st_in   = ST_MAC;
         end
         ST_MAC: begin
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd0: begin
                  // area product issued in the previous cycle lands here
                  if (term_ff == 2'd0) begin
                     area_in = mul_p[AREA_W-1:0];
                  end
               end
               2'd1: begin
                  s_in   = signed'(g_rd);
                  phi_in = mul_p[AREA_W-1:DIFF_W];
               end
               2'd2: begin
                  acc_in = acc_ff + ACC_W'(mul_p);
               end
               default: begin
                  acc_in  = acc_ff + (ACC_W'(mul_p) <<< DIFF_W);
                  term_in = term_ff + 2'd1;
                  if (term_ff == 2'd3) begin
                     st_in = ST_DCHK;
                  end
               end
            endcase
         end
         ST_DCHK: begin
            if (area_ff == '0) begin
               res_in = '0;
               oor_in = 1'b1;
               st_in  = ST_OUT;
            end else begin
               neg_in = acc_ff[ACC_W-1] ^ area_ff[AREA_W-1];
               st_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_in = neg_ff ? sat_neg[COORD_W-1:0] : sat_m[COORD_W-1:0];
               oor_in = 1'b0;
               st_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_oor_in   = oor_ff;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      cnt_ff      <= cnt_in;
      term_ff     <= term_in;
      ph_ff       <= ph_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      dx0_ff      <= dx0_in;
      dx1_ff      <= dx1_in;
      dy0_ff      <= dy0_in;
      dy1_ff      <= dy1_in;
      area_ff     <= area_in;
      phi_ff      <= phi_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
      rsp_oor_ff  <= rsp_oor_in;
      if (reset) begin
         st_ff        <= ST_IDLE;
         lx_ff        <= '0;
         ly_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         x_count_ff   <= COUNT_W'(256);
         y_count_ff   <= COUNT_W'(256);
      end else begin
         st_ff        <= st_in;
         lx_ff        <= lx_in;
         ly_ff        <= ly_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_we && csr_paddr[2] == REG_X_COUNT) begin
            x_count_ff <= csr_pwdata[COUNT_W-1:0];
         end
         if (cfg_we && csr_paddr[2] == REG_Y_COUNT) begin
            y_count_ff <= csr_pwdata[COUNT_W-1:0];
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_oor_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("flagged response carries a nonzero result");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> st_ff == ST_DIV)
      else $error("divider busy outside the divide state");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && op != OP_QUERY |=> st_ff == ST_IDLE)
      else $error("load request left the idle state");

   a_search_live: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_SCMP |-> (lx_ff != '0 || ly_ff != '0))
      else $error("search compare with both ranges empty");

endmodule
